FILE: sv/vda_pkg.sv
// vda_pkg: shared types, widths and codes for the 2d vector unit
package vda_pkg;

	// coordinate and length widths
	localparam int COORD_W       = 32;
	localparam int LEN_W         = COORD_W + 2;
	localparam int FRAC_BITS_DEF = 16;

	// operation codes
	localparam logic [1:0] ACT_ADD  = 2'd0;
	localparam logic [1:0] ACT_SUB  = 2'd1;
	localparam logic [1:0] ACT_LEN  = 2'd2;
	localparam logic [1:0] ACT_NORM = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	// input item
	typedef struct packed {
		logic [1:0]                action;
		logic signed [COORD_W-1:0] a_start_x;
		logic signed [COORD_W-1:0] a_start_y;
		logic signed [COORD_W-1:0] a_end_x;
		logic signed [COORD_W-1:0] a_end_y;
		logic signed [COORD_W-1:0] b_start_x;
		logic signed [COORD_W-1:0] b_start_y;
		logic signed [COORD_W-1:0] b_end_x;
		logic signed [COORD_W-1:0] b_end_y;
	} vec_in_t;

	// result item
	typedef struct packed {
		logic signed [COORD_W-1:0] res_start_x;
		logic signed [COORD_W-1:0] res_start_y;
		logic signed [COORD_W-1:0] res_end_x;
		logic signed [COORD_W-1:0] res_end_y;
		logic [LEN_W-1:0]          vec_length;
		logic [1:0]                status;
	} vec_out_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [1:0]                action;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic                      ovf;
		logic signed [COORD_W:0]   dx;
		logic signed [COORD_W:0]   dy;
	} vec_cls_t;

	// fields that ride along the back pipeline
	typedef struct packed {
		logic [1:0]                action;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic                      ovf;
		logic                      neg_x;
		logic                      neg_y;
		logic                      zero;
	} vec_side_t;

endpackage

FILE: sv/vda_front.sv
// vda_front: accepts items, does add/subtract with saturation and forms the offsets
module vda_front import vda_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  vec_in_t  in_data,
	output logic     cls_valid,
	input  logic     cls_ready,
	output vec_cls_t cls_data
);

	localparam int SUM_W = COORD_W + 2;

	logic                      vld_s1;
	vec_cls_t                  cls_s1;
	vec_cls_t                  cls_nxt;
	logic signed [SUM_W-1:0]   sum_x;
	logic signed [SUM_W-1:0]   sum_y;
	logic signed [COORD_W-1:0] base_x;
	logic signed [COORD_W-1:0] base_y;
	logic [COORD_W:0]          sat_x;
	logic [COORD_W:0]          sat_y;

	// clamp a widened sum to the coordinate range, flag in the top bit
	function automatic logic [COORD_W:0] sat_coord(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = {3'b000, {(COORD_W-1){1'b1}}};
		lo = {3'b111, {(COORD_W-1){1'b0}}};
		if (v > hi) begin
			return {1'b1, hi[COORD_W-1:0]};
		end else if (v < lo) begin
			return {1'b1, lo[COORD_W-1:0]};
		end
		return {1'b0, v[COORD_W-1:0]};
	endfunction

	// end point base and b offset sum
	assign base_x = (in_data.action == ACT_SUB) ? in_data.a_start_x : in_data.a_end_x;
	assign base_y = (in_data.action == ACT_SUB) ? in_data.a_start_y : in_data.a_end_y;
	assign sum_x  = {{2{base_x[COORD_W-1]}}, base_x}
		+ {{2{in_data.b_end_x[COORD_W-1]}}, in_data.b_end_x}
		- {{2{in_data.b_start_x[COORD_W-1]}}, in_data.b_start_x};
	assign sum_y  = {{2{base_y[COORD_W-1]}}, base_y}
		+ {{2{in_data.b_end_y[COORD_W-1]}}, in_data.b_end_y}
		- {{2{in_data.b_start_y[COORD_W-1]}}, in_data.b_start_y};
	assign sat_x  = sat_coord(sum_x);
	assign sat_y  = sat_coord(sum_y);

	// classify by action
	always_comb begin
		cls_nxt        = '0;
		cls_nxt.action = in_data.action;
		cls_nxt.dx     = {in_data.a_end_x[COORD_W-1], in_data.a_end_x}
			- {in_data.a_start_x[COORD_W-1], in_data.a_start_x};
		cls_nxt.dy     = {in_data.a_end_y[COORD_W-1], in_data.a_end_y}
			- {in_data.a_start_y[COORD_W-1], in_data.a_start_y};
		unique case (in_data.action)
			ACT_ADD: begin
				cls_nxt.start_x = in_data.a_start_x;
				cls_nxt.start_y = in_data.a_start_y;
				cls_nxt.end_x   = sat_x[COORD_W-1:0];
				cls_nxt.end_y   = sat_y[COORD_W-1:0];
				cls_nxt.ovf     = sat_x[COORD_W] | sat_y[COORD_W];
			end
			ACT_SUB: begin
				cls_nxt.start_x = in_data.a_end_x;
				cls_nxt.start_y = in_data.a_end_y;
				cls_nxt.end_x   = sat_x[COORD_W-1:0];
				cls_nxt.end_y   = sat_y[COORD_W-1:0];
				cls_nxt.ovf     = sat_x[COORD_W] | sat_y[COORD_W];
			end
			ACT_LEN, ACT_NORM: begin
				cls_nxt.ovf = 1'b0;
			end
		endcase
	end

	// output register, refills when empty or while the queue takes the held item
	assign in_ready  = !vld_s1 || cls_ready;
	assign cls_valid = vld_s1;
	assign cls_data  = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cls_s1 <= cls_nxt;
		end
	end

endmodule

FILE: sv/vda_div.sv
// vda_div: two-lane pipelined restoring fraction divider, one quotient bit per stage
module vda_div #(
	parameter int DW = 66,
	parameter int QB = 33,
	parameter int SB = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [1:0][DW-1:0]   num,
	input  logic [DW-1:0]        den,
	input  logic [SB-1:0]        side_in,
	output logic                 out_valid,
	output logic [1:0][QB-1:0]   quo,
	output logic [DW-1:0]        den_out,
	output logic [SB-1:0]        side_out
);

	logic [QB-1:0]             vld_s;
	logic [1:0][DW-1:0]        rem_s  [QB];
	logic [1:0][QB-1:0]        quo_s  [QB];
	logic [DW-1:0]             den_s  [QB];
	logic [SB-1:0]             side_s [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [1:0][DW-1:0] prem;
		logic [1:0][QB-1:0] pquo;
		logic [DW-1:0]      pden;
		logic [SB-1:0]      pside;
		logic               pvld;
		logic [1:0][DW-1:0] nrem;
		logic [1:0][QB-1:0] nquo;

		// previous stage or pipeline inputs
		if (k == 0) begin : g_first
			assign prem  = num;
			assign pquo  = '0;
			assign pden  = den;
			assign pside = side_in;
			assign pvld  = in_valid;
		end else begin : g_next
			assign prem  = rem_s[k-1];
			assign pquo  = quo_s[k-1];
			assign pden  = den_s[k-1];
			assign pside = side_s[k-1];
			assign pvld  = vld_s[k-1];
		end

		// compare and subtract per lane; first stage takes the integer bit
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [DW:0] trial;
			logic [DW:0] diff;
			logic        ge;
			if (k == 0) begin : g_int
				assign trial = {1'b0, prem[l]};
			end else begin : g_frac
				assign trial = {prem[l], 1'b0};
			end
			assign ge      = trial >= {1'b0, pden};
			assign diff    = trial - {1'b0, pden};
			assign nrem[l] = ge ? diff[DW-1:0] : trial[DW-1:0];
			assign nquo[l] = {pquo[l][QB-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= pvld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= nrem;
				quo_s[k]  <= nquo;
				den_s[k]  <= pden;
				side_s[k] <= pside;
			end
		end
	end

	assign out_valid = vld_s[QB-1];
	assign quo       = quo_s[QB-1];
	assign den_out   = den_s[QB-1];
	assign side_out  = side_s[QB-1];

endmodule

FILE: sv/vda_sqrt.sv
// vda_sqrt: multi-lane pipelined digit-by-digit integer square root, one root bit per stage
module vda_sqrt #(
	parameter int RW    = 66,
	parameter int LANES = 3,
	parameter int SB    = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [LANES-1:0][RW-1:0]      rad,
	input  logic [SB-1:0]                 side_in,
	output logic                          out_valid,
	output logic [LANES-1:0][RW/2-1:0]    root,
	output logic [SB-1:0]                 side_out
);

	localparam int NR   = RW / 2;
	localparam int REMW = NR + 2;

	logic [NR-1:0]                 vld_s;
	logic [LANES-1:0][RW-1:0]      rad_s  [NR];
	logic [LANES-1:0][REMW-1:0]    rem_s  [NR];
	logic [LANES-1:0][NR-1:0]      root_s [NR];
	logic [SB-1:0]                 side_s [NR];

	for (genvar k = 0; k < NR; k++) begin : g_stage
		logic [LANES-1:0][RW-1:0]   prad;
		logic [LANES-1:0][REMW-1:0] prem;
		logic [LANES-1:0][NR-1:0]   proot;
		logic [SB-1:0]              pside;
		logic                       pvld;
		logic [LANES-1:0][RW-1:0]   nrad;
		logic [LANES-1:0][REMW-1:0] nrem;
		logic [LANES-1:0][NR-1:0]   nroot;

		// previous stage or pipeline inputs
		if (k == 0) begin : g_first
			assign prad  = rad;
			assign prem  = '0;
			assign proot = '0;
			assign pside = side_in;
			assign pvld  = in_valid;
		end else begin : g_next
			assign prad  = rad_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
			assign pside = side_s[k-1];
			assign pvld  = vld_s[k-1];
		end

		// bring down two bits, try root*4+1
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [REMW+1:0] cur;
			logic [REMW+1:0] trial;
			logic [REMW+1:0] diff;
			logic            ge;
			assign cur      = {prem[l], prad[l][RW-1:RW-2]};
			assign trial    = {2'b00, proot[l], 2'b01};
			assign ge       = cur >= trial;
			assign diff     = cur - trial;
			assign nrem[l]  = ge ? diff[REMW-1:0] : cur[REMW-1:0];
			assign nroot[l] = {proot[l][NR-2:0], ge};
			assign nrad[l]  = {prad[l][RW-3:0], 2'b00};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= pvld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= nrad;
				rem_s[k]  <= nrem;
				root_s[k] <= nroot;
				side_s[k] <= pside;
			end
		end
	end

	assign out_valid = vld_s[NR-1];
	assign root      = root_s[NR-1];
	assign side_out  = side_s[NR-1];

endmodule

FILE: sv/vda_back.sv
// vda_back: squares, divider and square root pipelines and the result register
module vda_back import vda_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  vec_cls_t in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output vec_out_t out_data
);

	localparam int SW     = 2 * COORD_W + 2;
	localparam int QB     = 2 * FRAC_BITS + 1;
	localparam int RW     = (SW > 2 * FRAC_BITS + 2) ? SW : 2 * FRAC_BITS + 2;
	localparam int NR     = RW / 2;
	localparam int SIDE_W = $bits(vec_side_t);
	localparam int DSB    = SIDE_W;
	localparam logic [NR:0] UPOS = (NR+1)'({(COORD_W-1){1'b1}});
	localparam logic [NR:0] UNEG = (NR+1)'(1) << (COORD_W - 1);

	logic                 en;
	logic [COORD_W:0]     mag_x;
	logic [COORD_W:0]     mag_y;
	logic                 vld_s1;
	logic [SW-1:0]        sx_s1;
	logic [SW-1:0]        sy_s1;
	vec_side_t            side_s1;
	logic                 vld_s2;
	logic [SW-1:0]        sx_s2;
	logic [SW-1:0]        sy_s2;
	logic [SW-1:0]        s_s2;
	vec_side_t            side_s2;
	logic                 div_vld;
	logic [1:0][QB-1:0]   div_quo;
	logic [SW-1:0]        div_den;
	logic [DSB-1:0]       div_side;
	logic [2:0][RW-1:0]   sq_rad;
	logic                 sq_vld;
	logic [2:0][NR-1:0]   sq_root;
	logic [SIDE_W-1:0]    sq_side;
	vec_side_t            fin_side;
	logic [COORD_W:0]     unit_x;
	logic [COORD_W:0]     unit_y;
	vec_out_t             out_nxt;
	logic                 out_valid_q;
	vec_out_t             out_q;

	// signed unit component with clamp, flag in the top bit
	function automatic logic [COORD_W:0] unit_coord(input logic [NR-1:0] u, input logic neg);
		logic [NR:0] ue;
		ue = {1'b0, u};
		if (!neg) begin
			if (ue > UPOS) begin
				return {1'b1, UPOS[COORD_W-1:0]};
			end
			return {1'b0, ue[COORD_W-1:0]};
		end
		if (ue > UNEG) begin
			return {1'b1, UNEG[COORD_W-1:0]};
		end
		return {1'b0, -ue[COORD_W-1:0]};
	endfunction

	// whole pipeline moves when the result register can take a new item
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// stage 1: squared offsets
	assign mag_x = in_data.dx[COORD_W] ? -in_data.dx : in_data.dx;
	assign mag_y = in_data.dy[COORD_W] ? -in_data.dy : in_data.dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1           <= SW'(mag_x) * SW'(mag_x);
			sy_s1           <= SW'(mag_y) * SW'(mag_y);
			side_s1.action  <= in_data.action;
			side_s1.start_x <= in_data.start_x;
			side_s1.start_y <= in_data.start_y;
			side_s1.end_x   <= in_data.end_x;
			side_s1.end_y   <= in_data.end_y;
			side_s1.ovf     <= in_data.ovf;
			side_s1.neg_x   <= in_data.dx[COORD_W];
			side_s1.neg_y   <= in_data.dy[COORD_W];
			side_s1.zero    <= (in_data.dx == '0) && (in_data.dy == '0);
		end
	end

	// stage 2: sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2   <= sx_s1;
			sy_s2   <= sy_s1;
			s_s2    <= sx_s1 + sy_s1;
			side_s2 <= side_s1;
		end
	end

	// squared component over squared length, 2*FRAC_BITS fraction bits
	vda_div #(
		.DW (SW),
		.QB (QB),
		.SB (DSB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s2),
		.num      ({sx_s2, sy_s2}),
		.den      (s_s2),
		.side_in  (side_s2),
		.out_valid(div_vld),
		.quo      (div_quo),
		.den_out  (div_den),
		.side_out (div_side)
	);

	// length and both unit magnitudes share one root pipeline
	assign sq_rad[2] = RW'(div_den);
	assign sq_rad[1] = RW'(div_quo[1]);
	assign sq_rad[0] = RW'(div_quo[0]);

	vda_sqrt #(
		.RW   (RW),
		.LANES(3),
		.SB   (SIDE_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (div_vld),
		.rad      (sq_rad),
		.side_in  (div_side),
		.out_valid(sq_vld),
		.root     (sq_root),
		.side_out (sq_side)
	);

	// result assembly
	assign fin_side = sq_side;
	assign unit_x   = unit_coord(sq_root[1], fin_side.neg_x);
	assign unit_y   = unit_coord(sq_root[0], fin_side.neg_y);

	always_comb begin
		out_nxt = '0;
		unique case (fin_side.action)
			ACT_ADD, ACT_SUB: begin
				out_nxt.res_start_x = fin_side.start_x;
				out_nxt.res_start_y = fin_side.start_y;
				out_nxt.res_end_x   = fin_side.end_x;
				out_nxt.res_end_y   = fin_side.end_y;
				out_nxt.status      = fin_side.ovf ? ST_OVF : ST_OK;
			end
			ACT_LEN: begin
				out_nxt.vec_length = LEN_W'(sq_root[2]);
			end
			ACT_NORM: begin
				if (fin_side.zero) begin
					out_nxt.status = ST_ZERO;
				end else begin
					out_nxt.res_end_x  = unit_x[COORD_W-1:0];
					out_nxt.res_end_y  = unit_y[COORD_W-1:0];
					out_nxt.vec_length = LEN_W'(sq_root[2]);
					out_nxt.status     = (unit_x[COORD_W] | unit_y[COORD_W]) ? ST_OVF : ST_OK;
				end
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= out_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// zero-length normalize reports nothing but the status
	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status == ST_ZERO) |->
		(out_q.vec_length == '0) && (out_q.res_end_x == '0) && (out_q.res_end_y == '0))
		else $error("zero-length result carries nonzero fields");

	// a stalled first stage keeps its item
	a_stall_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!en && vld_s1 |=> vld_s1)
		else $error("first stage item lost under stall");

	// length never appears on add or subtract results
	a_len_only: assert property (@(posedge clk) disable iff (!arst_n)
		en && sq_vld && (fin_side.action == ACT_ADD || fin_side.action == ACT_SUB)
		|=> out_q.vec_length == '0)
		else $error("length set on add or subtract");

endmodule

FILE: sv/vector_2d_alu_core.sv
// vector_2d_alu_core: top level of the 2d vector unit, front, transfer queue and back
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------
//  input   | in        | in_valid / in_ready  | in_data  (vec_in_t)
//  result  | out       | out_valid / out_ready| out_data (vec_out_t)
//
// one item per cycle sustained while out_ready holds; items pass the front register,
// queue, square and sum stages, one-bit-per-stage divider and square root pipelines
// and result register (Q16.16 by default); arst_n clears all valid bits; payload
// registers are not reset; a stalled result freezes the back pipeline; the two-entry
// queue and the front register keep taking transfers until they fill
module vector_2d_alu_core import vda_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  vec_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output vec_out_t out_data
);

	localparam int QD  = 2;
	localparam int QPW = $clog2(QD);
	localparam int QCW = $clog2(QD + 1);

	logic           cls_valid;
	logic           cls_ready;
	vec_cls_t       cls_data;
	logic           back_ready;
	logic           q_push;
	logic           q_pop;
	logic [QPW-1:0] wptr_q;
	logic [QPW-1:0] rptr_q;
	logic [QCW-1:0] cnt_q;
	vec_cls_t       qmem [QD];

	vda_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cls_valid(cls_valid),
		.cls_ready(cls_ready),
		.cls_data (cls_data)
	);

	// queue between front and back
	assign cls_ready = cnt_q != QCW'(QD);
	assign q_push    = cls_valid && cls_ready;
	assign q_pop     = back_ready && (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (q_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (q_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCW'(q_push) - QCW'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) begin
			qmem[wptr_q] <= cls_data;
		end
	end

	vda_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cnt_q != '0),
		.in_ready (back_ready),
		.in_data  (qmem[rptr_q]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// queue occupancy stays within depth
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCW'(QD))
		else $error("queue overfilled");

	// the front only stalls input when the queue is full
	a_front_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (cnt_q == QCW'(QD)) && cls_valid)
		else $error("input stalled with queue space free");

endmodule
